// ===== hw/rtl/rac_pkg.sv =====
`default_nettype none

package rac_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int RANGE_BITS  = 16;
	localparam int MAX_REGIONS = 4;
	localparam int WIN_BITS    = 2;
	localparam int CH_BITS     = 8;
	localparam int RGB_BITS    = 3 * CH_BITS;
	localparam int PAIR_BITS   = 2 * RGB_BITS;

	// Numerator term t = (v - min) + (max - min) and span d = max - min.
	localparam int T_BITS   = ((SAMPLE_BITS > RANGE_BITS) ? SAMPLE_BITS : RANGE_BITS) + 3;
	localparam int D_BITS   = RANGE_BITS;
	localparam int DEN_BITS = D_BITS + 1;
	localparam int NUM_BITS = T_BITS + CH_BITS + 1;
	localparam int REM_BITS = DEN_BITS + CH_BITS;

	// Pipeline: lanes, merge, multiply, saturate, one stage per quotient bit.
	localparam int STAGES    = 4 + CH_BITS;
	localparam int ST_LANE   = 0;
	localparam int ST_MERGE  = 1;
	localparam int ST_MUL    = 2;
	localparam int ST_SAT    = 3;
	localparam int ST_DIV0   = 4;

	localparam int DATA_BITS = 64;
	localparam int ADDR_BITS = 6;

	localparam logic [2:0] REG_ACTIVE  = 3'd0;
	localparam logic [2:0] REG_COLORS0 = 3'd1;
	localparam logic [2:0] REG_COLORS1 = 3'd2;
	localparam logic [2:0] REG_RANGE0  = 3'd3;
	localparam logic [2:0] REG_RANGE1  = 3'd4;
	localparam logic [2:0] REG_RANGE2  = 3'd5;
	localparam logic [2:0] REG_RANGE3  = 3'd6;

	localparam logic [2:0] ACTIVE_RESET = 3'd4;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_zero;
		logic signed [SAMPLE_BITS-1:0] sample_one;
		logic signed [SAMPLE_BITS-1:0] sample_two;
		logic signed [SAMPLE_BITS-1:0] sample_three;
	} in_item_t;

	typedef struct packed {
		logic [CH_BITS-1:0]  red;
		logic [CH_BITS-1:0]  green;
		logic [CH_BITS-1:0]  blue;
		logic [WIN_BITS-1:0] winner;
	} out_item_t;

	typedef struct packed {
		logic                          act;
		logic signed [SAMPLE_BITS-1:0] smp;
		logic signed [T_BITS-1:0]      t;
		logic [D_BITS-1:0]             d;
		logic [RGB_BITS-1:0]           rgb;
	} lane_t;

	typedef struct packed {
		logic signed [T_BITS-1:0] t;
		logic [D_BITS-1:0]        d;
		logic [RGB_BITS-1:0]      rgb;
		logic [WIN_BITS-1:0]      winner;
	} pick_t;

	typedef struct packed {
		logic [STAGES-1:0] adv;
	} pipe_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rac_lane.sv =====
`default_nettype none

module rac_lane
	import rac_pkg::*;
(
	input  wire logic                          clk,
	input  wire pipe_ctl_t                     ctl,
	input  wire logic                          act,
	input  wire logic signed [SAMPLE_BITS-1:0] smp,
	input  wire logic [2*RANGE_BITS-1:0]       range_val,
	input  wire logic [RGB_BITS-1:0]           rgb,
	output lane_t                              lane_s1
);

	logic signed [T_BITS-1:0] v_ext;
	logic signed [T_BITS-1:0] mn_ext;
	logic signed [T_BITS-1:0] mx_ext;
	logic signed [T_BITS-1:0] span;
	logic signed [T_BITS-1:0] t_raw;
	logic                     open_range;

	assign v_ext      = T_BITS'(smp);
	assign mn_ext     = T_BITS'($signed(range_val[RANGE_BITS-1:0]));
	assign mx_ext     = T_BITS'($signed(range_val[2*RANGE_BITS-1:RANGE_BITS]));
	assign span       = mx_ext - mn_ext;
	assign t_raw      = v_ext - mn_ext + span;
	assign open_range = mx_ext > mn_ext;

	// Flat or inverted range: t = d = 1 turns the quotient into floor(c/2).
	always_ff @(posedge clk) begin
		if (ctl.adv[ST_LANE]) begin
			lane_s1.act <= act;
			lane_s1.smp <= smp;
			lane_s1.rgb <= rgb;
			if (open_range) begin
				lane_s1.t <= t_raw;
				lane_s1.d <= span[D_BITS-1:0];
			end else begin
				lane_s1.t <= T_BITS'(1);
				lane_s1.d <= D_BITS'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rac_merge.sv =====
`default_nettype none

module rac_merge
	import rac_pkg::*;
#(
	parameter int REGIONS = 4
) (
	input  wire logic      clk,
	input  wire pipe_ctl_t ctl,
	input  wire lane_t     lanes [REGIONS],
	output pick_t          pick_s2
);

	pick_t                         pick;
	logic signed [SAMPLE_BITS-1:0] best;

	// Strict compare keeps the lower index on a tie.
	always_comb begin
		best        = lanes[0].smp;
		pick.t      = lanes[0].t;
		pick.d      = lanes[0].d;
		pick.rgb    = lanes[0].rgb;
		pick.winner = '0;
		for (int i = 1; i < REGIONS; i++) begin
			if (lanes[i].act && (lanes[i].smp > best)) begin
				best        = lanes[i].smp;
				pick.t      = lanes[i].t;
				pick.d      = lanes[i].d;
				pick.rgb    = lanes[i].rgb;
				pick.winner = WIN_BITS'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv[ST_MERGE]) begin
			pick_s2 <= pick;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rac_scale.sv =====
`default_nettype none

module rac_scale
	import rac_pkg::*;
(
	input  wire logic                     clk,
	input  wire pipe_ctl_t                ctl,
	input  wire logic [CH_BITS-1:0]       chan,
	input  wire logic signed [T_BITS-1:0] t,
	input  wire logic [D_BITS-1:0]        d,
	output logic [CH_BITS-1:0]            result
);

	logic signed [NUM_BITS-1:0] num_s3;
	logic [DEN_BITS-1:0]        den_s3;
	logic                       neg;
	logic                       big;

	logic [REM_BITS-1:0] div_rem_s [0:CH_BITS];
	logic [DEN_BITS-1:0] div_den_s [0:CH_BITS];
	logic                div_sat_s [0:CH_BITS];
	logic [CH_BITS-1:0]  div_quo_s [0:CH_BITS];

	always_ff @(posedge clk) begin
		if (ctl.adv[ST_MUL]) begin
			num_s3 <= NUM_BITS'($signed({1'b0, chan})) * NUM_BITS'(t);
			den_s3 <= {d, 1'b0};
		end
	end

	// Quotient reaches 256 exactly when num >= d << 9.
	assign neg = num_s3[NUM_BITS-1];
	assign big = !neg && ($unsigned(num_s3) >=
		{{(NUM_BITS-REM_BITS){1'b0}}, den_s3, {CH_BITS{1'b0}}});

	always_ff @(posedge clk) begin
		if (ctl.adv[ST_SAT]) begin
			div_rem_s[0] <= (neg || big) ? '0 : num_s3[REM_BITS-1:0];
			div_den_s[0] <= den_s3;
			div_sat_s[0] <= big;
			div_quo_s[0] <= '0;
		end
	end

	for (genvar j = 0; j < CH_BITS; j++) begin : g_div
		localparam int BIT = CH_BITS - 1 - j;
		logic [REM_BITS-1:0] shifted;
		logic                ge;

		assign shifted = REM_BITS'(div_den_s[j]) << BIT;
		assign ge      = div_rem_s[j] >= shifted;

		always_ff @(posedge clk) begin
			if (ctl.adv[ST_DIV0 + j]) begin
				div_rem_s[j+1] <= ge ? (div_rem_s[j] - shifted) : div_rem_s[j];
				div_den_s[j+1] <= div_den_s[j];
				div_sat_s[j+1] <= div_sat_s[j];
				div_quo_s[j+1] <= div_quo_s[j] |
					(CH_BITS'(div_sat_s[j] || ge) << BIT);
			end
		end
	end

	assign result = div_quo_s[CH_BITS];

endmodule

`default_nettype wire

// ===== hw/rtl/region_argmax_colorizer_core.sv =====
`default_nettype none

// Channel   Handshake               Payload
// input     in_valid / in_stall     in_data  (four signed region samples)
// output    out_valid / out_stall   out_data (red, green, blue, winner)
// config    APB psel/penable/pwrite paddr (8-byte steps), pwdata, prdata
//
// One pixel enters per clock while in_stall is low. Each pixel goes through
// one lane stage, one merge stage, a multiply stage, a saturation stage and
// one restoring-division stage per quotient bit (eight). Reset clears the
// valid bits and the config registers. A stall on the output only halts
// stages that hold a pixel, so bubbles keep draining and input is taken
// until the pipeline is full.

module region_argmax_colorizer_core
	import rac_pkg::*;
#(
	parameter int REGIONS = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire in_item_t             in_data,

	output logic                      out_valid,
	input  wire logic                 out_stall,
	output out_item_t                 out_data,

	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [ADDR_BITS-1:0] paddr,
	input  wire logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0]      prdata,
	output logic                      pready
);

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [2:0]              active_q;
	logic [PAIR_BITS-1:0]    colors0_q;
	logic [PAIR_BITS-1:0]    colors1_q;
	logic [2*RANGE_BITS-1:0] range_q [MAX_REGIONS];
	logic                    cfg_wr;
	logic [2:0]              cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= ACTIVE_RESET;
			colors0_q <= '0;
			colors1_q <= '0;
			for (int i = 0; i < MAX_REGIONS; i++) begin
				range_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_ACTIVE:  active_q   <= pwdata[2:0];
				REG_COLORS0: colors0_q  <= pwdata[PAIR_BITS-1:0];
				REG_COLORS1: colors1_q  <= pwdata[PAIR_BITS-1:0];
				REG_RANGE0:  range_q[0] <= pwdata[2*RANGE_BITS-1:0];
				REG_RANGE1:  range_q[1] <= pwdata[2*RANGE_BITS-1:0];
				REG_RANGE2:  range_q[2] <= pwdata[2*RANGE_BITS-1:0];
				REG_RANGE3:  range_q[3] <= pwdata[2*RANGE_BITS-1:0];
				default: ;  // drop writes past the register list
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_ACTIVE:  prdata = DATA_BITS'(active_q);
			REG_COLORS0: prdata = DATA_BITS'(colors0_q);
			REG_COLORS1: prdata = DATA_BITS'(colors1_q);
			REG_RANGE0:  prdata = DATA_BITS'(range_q[0]);
			REG_RANGE1:  prdata = DATA_BITS'(range_q[1]);
			REG_RANGE2:  prdata = DATA_BITS'(range_q[2]);
			REG_RANGE3:  prdata = DATA_BITS'(range_q[3]);
			default:     prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Pipeline flow control: a stage advances when the output is taken
	// or when it or any stage after it is empty.
	// ---------------------------------------------------------------
	logic [STAGES-1:0] vld_q;
	pipe_ctl_t         ctl;

	for (genvar k = 0; k < STAGES; k++) begin : g_adv
		assign ctl.adv[k] = !out_stall || !(&vld_q[STAGES-1:k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < STAGES; k++) begin
				if (ctl.adv[k]) begin
					vld_q[k] <= (k == 0) ? in_valid : vld_q[(k == 0) ? 0 : k - 1];
				end
			end
		end
	end

	assign in_stall  = !ctl.adv[0];
	assign out_valid = vld_q[STAGES-1];

	// ---------------------------------------------------------------
	// Lanes: one per region, each prepares its own scaling terms
	// ---------------------------------------------------------------
	logic signed [SAMPLE_BITS-1:0] samples [MAX_REGIONS];
	logic [RGB_BITS-1:0]           rgbs    [MAX_REGIONS];
	lane_t                         lanes   [REGIONS];

	assign samples[0] = in_data.sample_zero;
	assign samples[1] = in_data.sample_one;
	assign samples[2] = in_data.sample_two;
	assign samples[3] = in_data.sample_three;

	assign rgbs[0] = colors0_q[RGB_BITS-1:0];
	assign rgbs[1] = colors0_q[PAIR_BITS-1:RGB_BITS];
	assign rgbs[2] = colors1_q[RGB_BITS-1:0];
	assign rgbs[3] = colors1_q[PAIR_BITS-1:RGB_BITS];

	for (genvar i = 0; i < REGIONS; i++) begin : g_lane
		logic act;

		// Region 0 always takes part; a count of zero behaves as one.
		assign act = (i == 0) || (3'(i) < active_q);

		rac_lane u_lane (
			.clk       (clk),
			.ctl       (ctl),
			.act       (act),
			.smp       (samples[i]),
			.range_val (range_q[i]),
			.rgb       (rgbs[i]),
			.lane_s1   (lanes[i])
		);
	end

	// ---------------------------------------------------------------
	// Merge: argmax over the active lanes
	// ---------------------------------------------------------------
	pick_t pick_s2;

	rac_merge #(
		.REGIONS (REGIONS)
	) u_merge (
		.clk     (clk),
		.ctl     (ctl),
		.lanes   (lanes),
		.pick_s2 (pick_s2)
	);

	// ---------------------------------------------------------------
	// Channel scaling: multiply, saturate, bit-per-stage divide
	// ---------------------------------------------------------------
	logic [CH_BITS-1:0] red;
	logic [CH_BITS-1:0] green;
	logic [CH_BITS-1:0] blue;

	rac_scale u_red (
		.clk    (clk),
		.ctl    (ctl),
		.chan   (pick_s2.rgb[3*CH_BITS-1:2*CH_BITS]),
		.t      (pick_s2.t),
		.d      (pick_s2.d),
		.result (red)
	);

	rac_scale u_green (
		.clk    (clk),
		.ctl    (ctl),
		.chan   (pick_s2.rgb[2*CH_BITS-1:CH_BITS]),
		.t      (pick_s2.t),
		.d      (pick_s2.d),
		.result (green)
	);

	rac_scale u_blue (
		.clk    (clk),
		.ctl    (ctl),
		.chan   (pick_s2.rgb[CH_BITS-1:0]),
		.t      (pick_s2.t),
		.d      (pick_s2.d),
		.result (blue)
	);

	// Carry the winner index alongside the scaling stages.
	logic [WIN_BITS-1:0] win_pipe_s [ST_MUL:STAGES-1];

	always_ff @(posedge clk) begin
		for (int k = ST_MUL; k < STAGES; k++) begin
			if (ctl.adv[k]) begin
				win_pipe_s[k] <= (k == ST_MUL) ? pick_s2.winner
					: win_pipe_s[(k == ST_MUL) ? ST_MUL : k - 1];
			end
		end
	end

	assign out_data.red    = red;
	assign out_data.green  = green;
	assign out_data.blue   = blue;
	assign out_data.winner = win_pipe_s[STAGES-1];

endmodule

`default_nettype wire

// ===== dv/region_argmax_colorizer_core_tb.sv =====
module region_argmax_colorizer_core_tb;
	import rac_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Slot 7 (byte address 56) sits inside the 64-byte map but holds no register; writes to it must vanish.
	localparam logic [2:0] REG_SPARE = 3'd7;

	// Corner pixels with the winner that plain argmax gives when all four regions compete.
	typedef struct packed {
		in_item_t            px;
		logic [WIN_BITS-1:0] win;
	} corner_row_t;

	localparam int CORNER_ROWS = 8;
	localparam int BLOCK_PIXELS = 88;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	in_item_t             in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_item_t            out_data;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [ADDR_BITS-1:0] paddr = '0;
	logic [DATA_BITS-1:0] pwdata = '0;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;

	// Shadow copy of the register file, updated whenever a write completes.
	logic [2:0]          active_cfg;
	logic [PAIR_BITS-1:0] colors_a_cfg;
	logic [PAIR_BITS-1:0] colors_b_cfg;
	logic [31:0]         range_cfg [MAX_REGIONS];

	out_item_t pixel_colors_q [$];
	int        mismatch_count = 0;
	int        idle_pct = 0;
	int        stall_pct = 0;

	corner_row_t corner_rows [CORNER_ROWS] = '{
		'{'{16'h0000, 16'h0000, 16'h0000, 16'h0000}, 2'd0},
		'{'{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 2'd0},
		'{'{16'h8000, 16'h8000, 16'h8000, 16'h8000}, 2'd0},
		'{'{16'h8000, 16'h8000, 16'h8000, 16'h7FFF}, 2'd3},
		'{'{16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000}, 2'd1},
		'{'{16'h8001, 16'h8000, 16'h7FFE, 16'h7FFD}, 2'd2},
		'{'{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA}, 2'd0},
		'{'{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}, 2'd1}
	};

	region_argmax_colorizer_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH at %0t: %s got %0h want %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Brightness scaling of one channel, exact integer form of
	// c * (0.5 + 0.5 * (v - min) / (max - min)), clipped to 0..255.
	function automatic logic [CH_BITS-1:0] shade_channel(logic [CH_BITS-1:0] c, int v,
			int mn, int mx);
		longint span, num, q;
		if (mx <= mn) return c >> 1;
		span = longint'(mx) - longint'(mn);
		num = longint'(c) * ((longint'(v) - longint'(mn)) + span);
		if (num < 0) return '0;
		q = num / (2 * span);
		if (q > 255) return 8'hFF;
		return q[CH_BITS-1:0];
	endfunction

	// Expected colored pixel for one input pixel under the current shadow registers.
	function automatic out_item_t colorize_pixel(in_item_t px);
		int                  smp [MAX_REGIONS];
		int                  n, best, mn, mx;
		logic [WIN_BITS-1:0] win;
		logic [RGB_BITS-1:0] rgb;
		out_item_t           res;
		smp[0] = int'(px.sample_zero);
		smp[1] = int'(px.sample_one);
		smp[2] = int'(px.sample_two);
		smp[3] = int'(px.sample_three);
		// A count of zero still lets region 0 through; counts past the lane total clamp.
		n = int'(active_cfg);
		if (n < 1) n = 1;
		if (n > MAX_REGIONS) n = MAX_REGIONS;
		best = smp[0];
		win = '0;
		// Strict compare keeps the lower index on a tie.
		for (int i = 1; i < n; i++) begin
			if (smp[i] > best) begin
				best = smp[i];
				win = WIN_BITS'(i);
			end
		end
		mn = int'(signed'(range_cfg[win][15:0]));
		mx = int'(signed'(range_cfg[win][31:16]));
		rgb = win[1] ? colors_b_cfg[win[0]*RGB_BITS +: RGB_BITS]
			: colors_a_cfg[win[0]*RGB_BITS +: RGB_BITS];
		res.red = shade_channel(rgb[23:16], best, mn, mx);
		res.green = shade_channel(rgb[15:8], best, mn, mx);
		res.blue = shade_channel(rgb[7:0], best, mn, mx);
		res.winner = win;
		return res;
	endfunction

	// Random pixel: plain noise, samples clustered around each region's range,
	// forced ties, or pure corner values.
	function automatic in_item_t random_pixel();
		logic [SAMPLE_BITS-1:0] s [MAX_REGIONS];
		int                     mode, mn, mx, t, lo, hi, pick;
		mode = $urandom_range(0, 9);
		for (int i = 0; i < MAX_REGIONS; i++) s[i] = SAMPLE_BITS'($urandom);
		if (mode >= 4 && mode <= 6) begin
			for (int i = 0; i < MAX_REGIONS; i++) begin
				mn = int'(signed'(range_cfg[i][15:0]));
				mx = int'(signed'(range_cfg[i][31:16]));
				if (mn > mx) begin
					t = mn;
					mn = mx;
					mx = t;
				end
				lo = mn - (mx - mn) - 2;
				hi = mx + (mx - mn) + 2;
				if (lo < -32768) lo = -32768;
				if (hi > 32767) hi = 32767;
				s[i] = SAMPLE_BITS'(lo + int'($urandom_range(0, hi - lo)));
			end
		end else if (mode == 7 || mode == 8) begin
			pick = $urandom_range(0, MAX_REGIONS - 1);
			for (int i = 0; i < MAX_REGIONS; i++)
				if ($urandom_range(0, 1)) s[i] = s[pick];
		end else if (mode == 9) begin
			for (int i = 0; i < MAX_REGIONS; i++) begin
				case ($urandom_range(0, 3))
					0: s[i] = 16'h8000;
					1: s[i] = 16'hFFFF;
					2: s[i] = 16'h0000;
					default: s[i] = 16'h7FFF;
				endcase
			end
		end
		return '{s[0], s[1], s[2], s[3]};
	endfunction

	// Two-phase APB write; one idle cycle after so back-to-back transfers never
	// drop and raise psel in the same step.
	task automatic apb_write(input logic [2:0] idx, input logic [DATA_BITS-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_BITS'({idx, 3'b000});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_ACTIVE:  active_cfg = val[2:0];
			REG_COLORS0: colors_a_cfg = val[PAIR_BITS-1:0];
			REG_COLORS1: colors_b_cfg = val[PAIR_BITS-1:0];
			REG_RANGE0:  range_cfg[0] = val[31:0];
			REG_RANGE1:  range_cfg[1] = val[31:0];
			REG_RANGE2:  range_cfg[2] = val[31:0];
			REG_RANGE3:  range_cfg[3] = val[31:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Read every register back and compare against the shadow copy.
	task automatic check_registers();
		logic [2:0]           idx;
		logic [DATA_BITS-1:0] want;
		for (int k = 0; k <= int'(REG_RANGE3); k++) begin
			idx = 3'(k);
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b0;
			paddr <= ADDR_BITS'({idx, 3'b000});
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			case (idx)
				REG_ACTIVE:  want = DATA_BITS'(active_cfg);
				REG_COLORS0: want = DATA_BITS'(colors_a_cfg);
				REG_COLORS1: want = DATA_BITS'(colors_b_cfg);
				REG_RANGE0:  want = DATA_BITS'(range_cfg[0]);
				REG_RANGE1:  want = DATA_BITS'(range_cfg[1]);
				REG_RANGE2:  want = DATA_BITS'(range_cfg[2]);
				default:     want = DATA_BITS'(range_cfg[3]);
			endcase
			if (prdata !== want) report_mismatch($sformatf("register %0d readback", k),
				prdata, want);
			psel <= 1'b0;
			penable <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Random register settings: counts of zero or past the legal range now and then,
	// spans that are normal, narrow, empty, inverted, full scale or raw random.
	task automatic load_random_config();
		int          r, mode, lo, hi, t;
		logic [31:0] rng;
		r = $urandom_range(0, 9);
		if (r < 8) apb_write(REG_ACTIVE, DATA_BITS'($urandom_range(1, 4)));
		else apb_write(REG_ACTIVE, DATA_BITS'($urandom_range(5, 7) & (r == 8 ? 7 : 0)));
		apb_write(REG_COLORS0, DATA_BITS'({$urandom, $urandom}));
		apb_write(REG_COLORS1, DATA_BITS'({$urandom, $urandom}));
		for (int i = 0; i < MAX_REGIONS; i++) begin
			mode = $urandom_range(0, 9);
			lo = int'($urandom_range(0, 65535)) - 32768;
			hi = int'($urandom_range(0, 65535)) - 32768;
			if (mode <= 4 && lo > hi || mode == 7 && lo < hi) begin
				t = lo;
				lo = hi;
				hi = t;
			end
			if (mode == 5) begin
				lo = int'($urandom_range(0, 200)) - 100;
				hi = lo + int'($urandom_range(1, 20));
			end else if (mode == 6) begin
				hi = lo;
			end else if (mode == 8) begin
				lo = -32768;
				hi = 32767;
			end
			rng = {16'(hi), 16'(lo)};
			if (mode == 9) rng = $urandom;
			apb_write(3'(int'(REG_RANGE0) + i), DATA_BITS'(rng));
		end
		check_registers();
	endtask

	// Offer one pixel, with random idle cycles first, and hold it until the
	// transaction goes through; queue its expected color at that edge.
	task automatic send_pixel(input in_item_t px, input bit typed, input out_item_t want);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= px;
		do @(posedge clk); while (in_stall);
		pixel_colors_q.push_back(typed ? want : colorize_pixel(px));
	endtask

	// Drop valid and hold until every queued color has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pixel_colors_q.size() != 0);
	endtask

	// Output side: sample the transaction on the pre-edge values, then roll the
	// stall for the next cycle.
	always @(posedge clk) begin : color_checker
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pixel_colors_q.size() == 0) begin
				report_mismatch("output with nothing pending", 64'(out_data), '0);
			end else begin
				want = pixel_colors_q.pop_front();
				if (out_data.red !== want.red)
					report_mismatch("red", 64'(out_data.red), 64'(want.red));
				if (out_data.green !== want.green)
					report_mismatch("green", 64'(out_data.green), 64'(want.green));
				if (out_data.blue !== want.blue)
					report_mismatch("blue", 64'(out_data.blue), 64'(want.blue));
				if (out_data.winner !== want.winner)
					report_mismatch("winner", 64'(out_data.winner), 64'(want.winner));
			end
		end
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	initial begin : stimulus
		int idle_plan [4];
		int stall_plan [4];
		idle_plan = '{0, 59, 0, 24};
		stall_plan = '{0, 0, 59, 24};
		active_cfg = ACTIVE_RESET;
		colors_a_cfg = '0;
		colors_b_cfg = '0;
		for (int i = 0; i < MAX_REGIONS; i++) range_cfg[i] = '0;

		// Hold reset at the start, then release it once and never again.
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_registers();

		// Reset colors are black and spans empty, so every channel comes out zero
		// and only the argmax and its tie rule show.
		foreach (corner_rows[i])
			send_pixel(corner_rows[i].px, 1'b1, '{8'd0, 8'd0, 8'd0, corner_rows[i].win});
		wait_drained();

		// White everywhere; region 0 has a tiny span so corner samples clip both
		// ways, region 1 spans full scale, region 2 has min equal to max, region 3
		// is inverted. A count of seven must clamp to four lanes.
		apb_write(REG_ACTIVE, 64'd7);
		apb_write(REG_COLORS0, 64'hFFFFFF_FFFFFF);
		apb_write(REG_COLORS1, 64'hFFFFFF_FFFFFF);
		apb_write(REG_RANGE0, 64'h000A_FFF6);
		apb_write(REG_RANGE1, 64'h7FFF_8000);
		apb_write(REG_RANGE2, 64'h0005_0005);
		apb_write(REG_RANGE3, 64'h8000_7FFF);
		check_registers();
		foreach (corner_rows[i]) send_pixel(corner_rows[i].px, 1'b0, '0);
		wait_drained();

		// A count of zero lets region 0 win every pixel; the write to the spare
		// address must leave all registers alone.
		apb_write(REG_ACTIVE, 64'd0);
		apb_write(REG_COLORS0, 64'h2080FF_C35A01);
		apb_write(REG_COLORS1, 64'hABCDEF_123456);
		apb_write(REG_RANGE0, 64'h012C_FF9C);
		apb_write(REG_RANGE1, 64'h0000_0000);
		apb_write(REG_RANGE2, 64'h7FFF_7FFF);
		apb_write(REG_RANGE3, 64'hFFFF_0001);
		apb_write(REG_SPARE, '1);
		check_registers();
		foreach (corner_rows[i]) send_pixel(corner_rows[i].px, 1'b0, '0);
		wait_drained();

		// Random traffic: four idle and stall patterns, two register settings each.
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = idle_plan[ph];
			stall_pct = stall_plan[ph];
			for (int blk = 0; blk < 2; blk++) begin
				load_random_config();
				for (int k = 0; k < BLOCK_PIXELS; k++) begin
					send_pixel(random_pixel(), 1'b0, '0);
					// Let the pipeline run dry once mid-stream.
					if (ph == 1 && blk == 0 && k == BLOCK_PIXELS / 2) wait_drained();
				end
				wait_drained();
			end
		end

		// Allow any stray output past the pipeline depth to surface.
		stall_pct = 0;
		repeat (STAGES + 8) @(posedge clk);
		if (mismatch_count == 0)
			$display("region_argmax_colorizer_core test passed");
		else
			$display("region_argmax_colorizer_core test failed");
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("region_argmax_colorizer_core test failed");
		$finish;
	end

endmodule
